>>> rtl/particle_euler_integrator_defines.svh
// assertion macros for the particle euler integrator
// used by particle_euler_integrator.sv, expects i_clk and i_rst_n in scope
`ifndef PARTICLE_EULER_INTEGRATOR_DEFINES_SVH
`define PARTICLE_EULER_INTEGRATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define PEI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("pei assertion failed");
`define PEI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error("pei assertion failed");
`else
`define PEI_ASSERT_IMPL(label, ante, cons)
`define PEI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/pei_pkg.sv
// shared types, constants and saturation helper for the particle integrator
// no dependencies
`default_nettype none

package pei_pkg;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic signed [31:0] force_sum;
        logic [31:0]        inverse_mass;
        logic [16:0]        damping;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_position;
        logic signed [31:0] new_velocity;
        logic signed [31:0] new_acceleration;
        logic               held_unchanged;
        logic               saturated;
    } t_out;

    // divide-by-1000 unit widths
    localparam int DIV_XW = 47;
    localparam int DIV_QW = 38;
    localparam int DIV_YW = DIV_XW - 3;
    localparam logic [37:0] DIV_RECIP = 38'd140737488355; // floor(2^44 / 125)
    localparam logic [46:0] MS_HALF = 47'd500;

    // damping classes
    localparam logic [1:0] D_NORM = 2'd0;
    localparam logic [1:0] D_ZERO = 2'd1;
    localparam logic [1:0] D_ONE  = 2'd2;

    localparam logic [16:0] Q16_ONE = 17'd65536;

    // clip to signed 32 bits, msb of result is the clip flag
    function automatic logic [32:0] sat32(input logic signed [71:0] x);
        logic [32:0] res;
        if (x > 72'sd2147483647) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (x < -72'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, x[31:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pei_div1000.sv
// pipelined floor(x / 1000) by reciprocal multiply and one correction step
// depends on pei_pkg
`default_nettype none

module pei_div1000
    import pei_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [DIV_XW-1:0] i_x,
    output logic      [DIV_QW-1:0] o_q
);

    logic [DIV_YW-1:0] y;
    logic [59:0]       r_ph;
    logic [59:0]       r_pl;
    logic [DIV_YW-1:0] r_y1;
    logic [81:0]       sum;
    logic [DIV_QW-1:0] r_q0;
    logic [DIV_YW-1:0] r_y2;
    logic [DIV_YW-1:0] q125;
    logic [DIV_YW-1:0] rem;
    logic [DIV_QW-1:0] r_q;

    // x / 1000 = (x >> 3) / 125
    assign y = i_x[DIV_XW-1:3];

    always_ff @(posedge i_clk) begin
        r_ph <= 60'(y[43:22]) * 60'(DIV_RECIP);
        r_pl <= 60'(y[21:0]) * 60'(DIV_RECIP);
        r_y1 <= y;
    end

    assign sum = {r_ph, 22'd0} + 82'(r_pl);

    always_ff @(posedge i_clk) begin
        r_q0 <= sum[81:44];
        r_y2 <= r_y1;
    end

    // estimate is low by at most one
    assign q125 = (44'(r_q0) << 7) - (44'(r_q0) << 1) - 44'(r_q0);
    assign rem  = r_y2 - q125;

    always_ff @(posedge i_clk) begin
        if (rem >= 44'd125) begin
            r_q <= r_q0 + 38'd1;
        end else begin
            r_q <= r_q0;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

>>> rtl/particle_euler_integrator.sv
// top level: explicit euler update of one particle axis with damping
// depends on pei_pkg, pei_div1000 and particle_euler_integrator_defines.svh
//
//  channel   signals                      transfer when
//  input     i_start, o_busy, i_item      i_start high and o_busy low
//  result    o_done, o_result             o_done high, one cycle, no back pressure
//  config    i_cfg_we, i_cfg_data         i_cfg_we high
//
// one item enters per cycle; each item passes, in order, through the
// input register, eight compute stages and the output register; the three
// divide-by-1000 units run alongside stages 2 to 6 and feed the new position,
// the damping factor and the undamped velocity
// o_busy is always low since the receiver cannot stall and nothing is held back
// synchronous active-low reset clears the valid chain and the time step register
`default_nettype none
`include "particle_euler_integrator_defines.svh"

module particle_euler_integrator
    import pei_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire t_in         i_item,
    output logic             o_done,
    output t_out             o_result,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data
);

    localparam int LAT = 10;

    // sideband carried along the pipe
    typedef struct packed {
        logic signed [31:0] p;
        logic signed [31:0] v;
        logic signed [31:0] a;
        logic signed [31:0] pos;
        logic signed [39:0] v1;
        logic [16:0]        f;
        logic [1:0]         dcls;
        logic               fneg;
        logic               vneg;
        logic               aneg;
        logic               held;
        logic               clip;
    } t_side;

    logic [15:0] r_time_step;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;
    t_in   r_in;
    t_side r_sd [1:8];
    t_side n_sd [1:8];
    t_out  r_out;
    t_out  n_out;

    logic [46:0] r1_xpv, n1_xpv;
    logic [63:0] r1_prod, n1_prod;
    logic [20:0] r1_n, n1_n;
    logic [46:0] r2_xn, n2_xn;
    logic [46:0] r3_xa, n3_xa;
    logic [56:0] r8_vp, n8_vp;

    logic [DIV_QW-1:0] pv_q;
    logic [DIV_QW-1:0] y_q;
    logic [DIV_QW-1:0] av_q;

    assign o_busy = 1'b0;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= 16'd0;
        end else if (i_cfg_we) begin
            r_time_step <= i_cfg_data;
        end
    end

    // valid chain, stage 0 is the input register, last stage is the output register
    assign n_vld = {r_vld[LAT-2:0], i_start & ~o_busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;
    end

    // stage 1: v*ms, f*invmass products, damping log magnitude
    always_comb begin
        logic [31:0] absv;
        logic [31:0] absf;
        logic [4:0]  k;
        logic [4:0]  sh;
        logic [32:0] dsh;
        logic [15:0] d;
        d    = r_in.damping[15:0];
        absv = r_in.velocity[31] ? 32'(-r_in.velocity) : 32'(r_in.velocity);
        absf = r_in.force_sum[31] ? 32'(-r_in.force_sum) : 32'(r_in.force_sum);
        k = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (d[i]) begin
                k = 5'(i);
            end
        end
        sh  = 5'd16 - k;
        dsh = 33'(d) << sh;
        n1_n    = {sh, 16'd0} - 21'({1'b0, dsh[15:0]});
        n1_xpv  = 47'(absv) * 47'(r_time_step) + MS_HALF;
        n1_prod = 64'(absf) * 64'(r_in.inverse_mass) + (64'd1 << (FRAC_BITS - 1));

        n_sd[1]      = '0;
        n_sd[1].p    = r_in.position;
        n_sd[1].v    = r_in.velocity;
        n_sd[1].a    = r_in.acceleration;
        n_sd[1].fneg = r_in.force_sum[31];
        n_sd[1].vneg = r_in.velocity[31];
        n_sd[1].held = (r_in.inverse_mass == 32'd0) || (r_time_step == 16'd0);
        if (r_in.damping[16]) begin
            n_sd[1].dcls = D_ONE;
        end else if (d == 16'd0) begin
            n_sd[1].dcls = D_ZERO;
        end else begin
            n_sd[1].dcls = D_NORM;
        end
    end

    // stage 2: new acceleration with saturation, log magnitude times ms
    // held items keep the original acceleration for the pass-through
    always_comb begin
        logic [63:0]        qf;
        logic signed [71:0] anew;
        logic [32:0]        s;
        qf   = r1_prod >> FRAC_BITS;
        anew = 72'(r_sd[1].a)
             + (r_sd[1].fneg ? -$signed({8'd0, qf}) : $signed({8'd0, qf}));
        s    = sat32(anew);
        n_sd[2]      = r_sd[1];
        n_sd[2].a    = r_sd[1].held ? r_sd[1].a : $signed(s[31:0]);
        n_sd[2].clip = r_sd[1].clip | s[32];
        n2_xn        = 47'(r1_n) * 47'(r_time_step) + MS_HALF;
    end

    // stage 3: new acceleration times ms
    always_comb begin
        logic [31:0] absa;
        absa = r_sd[2].a[31] ? 32'(-r_sd[2].a) : 32'(r_sd[2].a);
        n_sd[3]      = r_sd[2];
        n_sd[3].aneg = r_sd[2].a[31];
        n3_xa        = 47'(absa) * 47'(r_time_step) + MS_HALF;
    end

    pei_div1000 u_div_pv (
        .i_clk (i_clk),
        .i_x   (r1_xpv),
        .o_q   (pv_q)
    );

    pei_div1000 u_div_y (
        .i_clk (i_clk),
        .i_x   (r2_xn),
        .o_q   (y_q)
    );

    pei_div1000 u_div_av (
        .i_clk (i_clk),
        .i_x   (r3_xa),
        .o_q   (av_q)
    );

    assign n_sd[4] = r_sd[3];

    // stage 5: new position
    always_comb begin
        logic signed [71:0] pos;
        logic [32:0]        s;
        pos = 72'(r_sd[4].p)
            + (r_sd[4].vneg ? -$signed({34'd0, pv_q}) : $signed({34'd0, pv_q}));
        s   = sat32(pos);
        n_sd[5]      = r_sd[4];
        n_sd[5].pos  = $signed(s[31:0]);
        n_sd[5].clip = r_sd[4].clip | s[32];
    end

    // stage 6: damping factor from y = round(n * ms / 1000)
    always_comb begin
        logic [21:0] q;
        logic [17:0] base;
        logic [4:0]  amt;
        q    = y_q[37:16];
        base = 18'd131072 - 18'(y_q[15:0]);
        amt  = q[4:0] + 5'd1;
        n_sd[6] = r_sd[5];
        case (r_sd[5].dcls)
            D_ONE:   n_sd[6].f = Q16_ONE;
            D_ZERO:  n_sd[6].f = 17'd0;
            default: begin
                if (q > 22'd16) begin
                    n_sd[6].f = 17'd0;
                end else begin
                    n_sd[6].f = 17'(base >> amt);
                end
            end
        endcase
    end

    // stage 7: undamped velocity
    always_comb begin
        n_sd[7]    = r_sd[6];
        n_sd[7].v1 = 40'(r_sd[6].v)
                   + (r_sd[6].aneg ? -$signed({2'd0, av_q}) : $signed({2'd0, av_q}));
    end

    // stage 8: damping multiply
    always_comb begin
        logic [39:0] absv1;
        absv1 = r_sd[7].v1[39] ? 40'(-r_sd[7].v1) : 40'(r_sd[7].v1);
        n_sd[8] = r_sd[7];
        n8_vp   = 57'(absv1) * 57'(r_sd[7].f) + 57'd32768;
    end

    // stage 9: scale, saturate, select pass-through
    always_comb begin
        logic [40:0]        mag;
        logic signed [71:0] vw;
        logic [32:0]        s;
        mag = 41'(r8_vp >> 16);
        vw  = r_sd[8].v1[39] ? -$signed({31'd0, mag}) : $signed({31'd0, mag});
        s   = sat32(vw);
        if (r_sd[8].held) begin
            n_out.new_position     = r_sd[8].p;
            n_out.new_velocity     = r_sd[8].v;
            n_out.new_acceleration = r_sd[8].a;
            n_out.held_unchanged   = 1'b1;
            n_out.saturated        = 1'b0;
        end else begin
            n_out.new_position     = r_sd[8].pos;
            n_out.new_velocity     = $signed(s[31:0]);
            n_out.new_acceleration = r_sd[8].a;
            n_out.held_unchanged   = 1'b0;
            n_out.saturated        = r_sd[8].clip | s[32];
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        for (int i = 1; i <= 8; i++) begin
            r_sd[i] <= n_sd[i];
        end
        r1_xpv  <= n1_xpv;
        r1_prod <= n1_prod;
        r1_n    <= n1_n;
        r2_xn   <= n2_xn;
        r3_xa   <= n3_xa;
        r8_vp   <= n8_vp;
        r_out   <= n_out;
    end

    assign o_done   = r_vld[LAT-1];
    assign o_result = r_out;

    // held items are never flagged as clipped
    `PEI_ASSERT_IMPL(a_held_no_sat, o_done && o_result.held_unchanged, !o_result.saturated)
    // every input transfer yields a result after the fixed latency
    `PEI_ASSERT_IMPL(a_latency, i_start && !o_busy, ##(LAT) o_done)
    // the damping factor never exceeds one
    `PEI_ASSERT_IMPL(a_f_bound, r_vld[6], r_sd[6].f <= Q16_ONE)
    // a result is never shown without an item in the stage before the output register
    `PEI_ASSERT_NEXT(a_done_src, !r_vld[LAT-2], !o_done)

endmodule

`default_nettype wire
